FILE: src/rpn_pkg.sv
// Shared types, symbol codes and the helper function of the postfix evaluator.
`default_nettype none

package rpn_pkg;

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_MUL   = 8'h2A;
  localparam logic [7:0] SYM_DIV   = 8'h2F;
  localparam logic [7:0] SYM_ZERO  = 8'h30;

  localparam int unsigned OUT_WIDTH = 32;

  localparam int unsigned FLAG_UNDER = 0;
  localparam int unsigned FLAG_OVER  = 1;
  localparam int unsigned FLAG_DIVZ  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_L,
    ST_EXEC,
    ST_WAIT,
    ST_RD_TOP,
    ST_EMIT
  } state_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  function automatic logic is_operator(logic [7:0] sym);
    return (sym == SYM_PLUS) || (sym == SYM_MINUS) || (sym == SYM_MUL) || (sym == SYM_DIV);
  endfunction

endpackage

`default_nettype wire

FILE: src/rpn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/rpn_alu.sv
// Iterative shift-add multiplier and restoring signed divider, one bit per cycle.
`default_nettype none

module rpn_alu
  import rpn_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire alu_req_t     req_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output alu_rsp_t          rsp_o,
  output logic      [W-1:0] result_o
);

  localparam int unsigned SW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          fin_q, fin_d;
  logic          done_q, done_d;
  logic          dz_q, dz_d;
  logic [SW-1:0] step_q, step_d;
  alu_op_e       op_q;
  logic          neg_q;
  logic [W-1:0]  acc_q, x_q, y_q, res_q;
  logic [W-1:0]  acc_nxt, x_nxt;
  logic [W-1:0]  mag_a, mag_b;
  logic [W:0]    rem_sh;
  logic          ge;

  assign mag_a  = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign mag_b  = b_i[W-1] ? (W'(0) - b_i) : b_i;
  assign rem_sh = {acc_q, x_q[W-1]};
  assign ge     = rem_sh >= {1'b0, y_q};

  always_comb begin
    if (op_q == ALU_MUL) begin
      acc_nxt = acc_q + (x_q[0] ? y_q : W'(0));
      x_nxt   = x_q >> 1;
    end else begin
      acc_nxt = ge ? W'(rem_sh - {1'b0, y_q}) : rem_sh[W-1:0];
      x_nxt   = {x_q[W-2:0], ge};
    end
  end

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    dz_d   = 1'b0;
    step_d = step_q;
    if (req_i.start) begin
      if (req_i.op == ALU_DIV && mag_b == W'(0)) begin
        done_d = 1'b1;
        dz_d   = 1'b1;
      end else begin
        busy_d = 1'b1;
        step_d = SW'(W);
      end
    end else if (busy_q) begin
      step_d = step_q - SW'(1);
      if (step_q == SW'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      dz_q   <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      dz_q   <= dz_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      acc_q <= '0;
      if (req_i.op == ALU_MUL) begin
        x_q   <= a_i;
        y_q   <= b_i;
        neg_q <= 1'b0;
      end else begin
        x_q   <= mag_a;
        y_q   <= mag_b;
        neg_q <= a_i[W-1] ^ b_i[W-1];
      end
      res_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_nxt;
      x_q   <= x_nxt;
      if (op_q == ALU_MUL) begin
        y_q <= y_q << 1;
      end
    end else if (fin_q) begin
      if (op_q == ALU_MUL) begin
        res_q <= acc_q;
      end else begin
        res_q <= neg_q ? (W'(0) - x_q) : x_q;
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.div_zero = dz_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

FILE: src/postfix_expression_evaluator.sv
// Steps: an operand is pushed from ST_IDLE; + and - pass ST_POP_L and ST_EXEC; * and / also
// wait in ST_WAIT for the bit-serial multiply and divide unit, which answers without iterating
// when the divisor is zero. A last item then passes ST_RD_TOP to read the top entry and ST_EMIT
// to load the output register, and stays there while the previous result waits for its transfer.
// One item is in work at a time; in_ready_o is high only while the sequencer is idle.
// Reset clears the count, the sticky flags and the output valid; only pushed entries are read.
`default_nettype none

module postfix_expression_evaluator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           symbol_i,
  input  wire logic                 last_symbol_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [OUT_WIDTH-1:0] value_o,
  output logic                      underflow_o,
  output logic                      overflow_o,
  output logic                      divide_by_zero_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W  = VALUE_WIDTH;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d, cnt_dec;
  logic [2:0]     flags_q, flags_d;
  logic [7:0]     sym_q, sym_d;
  logic           last_q, last_d;
  logic           r_hit_q, r_hit_d;
  logic           l_hit_q, l_hit_d;
  logic           top_hit_q, top_hit_d;
  logic [W-1:0]   right_q, right_d;
  logic           out_valid_q, out_valid_d;
  logic [OUT_WIDTH-1:0] value_q, value_d;
  logic [2:0]     oflags_q, oflags_d;

  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [W-1:0]   wdata, rdata;
  logic           push_req, pop_req, pop_hit;
  logic [W-1:0]   push_val, left_val, alu_res;
  logic [OUT_WIDTH-1:0] top32;
  alu_req_t       alu_req;
  alu_rsp_t       alu_rsp;

  assign cnt_dec = cnt_q - CW'(1);

  generate
    if (W >= OUT_WIDTH) begin : g_trunc
      assign top32 = rdata[OUT_WIDTH-1:0];
    end else begin : g_ext
      assign top32 = {{(OUT_WIDTH - W){1'b0}}, rdata};
    end
  endgenerate

  rpn_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rpn_alu #(
    .W (W)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (left_val),
    .b_i      (right_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_res)
  );

  assign left_val = l_hit_q ? rdata : '1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (is_operator(symbol_i)) begin
            state_d = ST_POP_L;
          end else if (last_symbol_i) begin
            state_d = ST_RD_TOP;
          end
        end
      end
      ST_POP_L: state_d = ST_EXEC;
      ST_EXEC: begin
        if (sym_q == SYM_MUL || sym_q == SYM_DIV) begin
          state_d = ST_WAIT;
        end else begin
          state_d = last_q ? ST_RD_TOP : ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (alu_rsp.done) begin
          state_d = last_q ? ST_RD_TOP : ST_IDLE;
        end
      end
      ST_RD_TOP: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    push_req      = 1'b0;
    pop_req       = 1'b0;
    push_val      = '0;
    alu_req.start = 1'b0;
    alu_req.op    = (sym_q == SYM_MUL) ? ALU_MUL : ALU_DIV;
    sym_d         = sym_q;
    last_d        = last_q;
    r_hit_d       = r_hit_q;
    l_hit_d       = l_hit_q;
    right_d       = right_q;
    top_hit_d     = top_hit_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    value_d       = value_q;
    oflags_d      = oflags_q;
    cnt_d         = cnt_q;
    flags_d       = flags_q;
    we            = 1'b0;
    waddr         = cnt_q[AW-1:0];
    wdata         = push_val;
    re            = 1'b0;
    raddr         = cnt_dec[AW-1:0];
    pop_hit       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sym_d  = symbol_i;
          last_d = last_symbol_i;
          if (is_operator(symbol_i)) begin
            pop_req = 1'b1;
          end else begin
            push_req = 1'b1;
            push_val = W'(symbol_i) - W'(SYM_ZERO);
          end
        end
      end
      ST_POP_L: begin
        right_d = r_hit_q ? rdata : '1;
        pop_req = 1'b1;
      end
      ST_EXEC: begin
        if (sym_q == SYM_PLUS) begin
          push_req = 1'b1;
          push_val = left_val + right_q;
        end else if (sym_q == SYM_MINUS) begin
          push_req = 1'b1;
          push_val = left_val - right_q;
        end else begin
          alu_req.start = 1'b1;
        end
      end
      ST_WAIT: begin
        if (alu_rsp.done) begin
          push_req = 1'b1;
          push_val = alu_res;
          if (alu_rsp.div_zero) begin
            flags_d[FLAG_DIVZ] = 1'b1;
          end
        end
      end
      ST_RD_TOP: begin
        top_hit_d = cnt_q != '0;
        re        = cnt_q != '0;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = top_hit_q ? top32 : '1;
          oflags_d    = flags_q;
          cnt_d       = '0;
          flags_d     = '0;
        end
      end
      default: ;
    endcase

    wdata = push_val;
    if (pop_req) begin
      if (cnt_q == '0) begin
        flags_d[FLAG_UNDER] = 1'b1;
      end else begin
        re      = 1'b1;
        cnt_d   = cnt_dec;
        pop_hit = 1'b1;
      end
      if (state_q == ST_IDLE) begin
        r_hit_d = pop_hit;
      end else begin
        l_hit_d = pop_hit;
      end
    end
    if (push_req) begin
      if (cnt_q >= CW'(STACK_DEPTH)) begin
        flags_d[FLAG_OVER] = 1'b1;
      end else begin
        we    = 1'b1;
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    last_q    <= last_d;
    r_hit_q   <= r_hit_d;
    l_hit_q   <= l_hit_d;
    right_q   <= right_d;
    top_hit_q <= top_hit_d;
    value_q   <= value_d;
    oflags_q  <= oflags_d;
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = value_q;
  assign underflow_o      = oflags_q[FLAG_UNDER];
  assign overflow_o       = oflags_q[FLAG_OVER];
  assign divide_by_zero_o = oflags_q[FLAG_DIVZ];

endmodule

`default_nettype wire

FILE: src/rpn_checker.sv
// Port-level checker for the postfix evaluator and its bind to the top level.
`default_nettype none

module rpn_checker
  import rpn_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic [7:0]           symbol_i,
  input wire logic                 last_symbol_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [OUT_WIDTH-1:0] value_o,
  input wire logic                 underflow_o,
  input wire logic                 overflow_o,
  input wire logic                 divide_by_zero_o
);

  logic in_xfer;
  logic op_sym;

  assign in_xfer = in_valid_i && in_ready_o;
  assign op_sym  = (symbol_i == SYM_PLUS) || (symbol_i == SYM_MINUS) ||
                   (symbol_i == SYM_MUL) || (symbol_i == SYM_DIV);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result valid dropped before its transfer.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(value_o) && $stable(underflow_o) && $stable(overflow_o) &&
      $stable(divide_by_zero_o))
    else $error("Result payload changed while stalled.");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_symbol_i |=> !in_ready_o)
    else $error("Input taken again before the final result was produced.");

  a_op_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && op_sym |=> !in_ready_o)
    else $error("Input taken again while an operator was still in work.");

  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result appeared without the evaluator being busy.");

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .symbol_i         (symbol_i),
  .last_symbol_i    (last_symbol_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .value_o          (value_o),
  .underflow_o      (underflow_o),
  .overflow_o       (overflow_o),
  .divide_by_zero_o (divide_by_zero_o)
);

`default_nettype wire
